### hw/rtl/bia_pkg.sv
// Shared types, constants and helpers of the bitmap identifier allocator.
package bia_pkg;

    // Identifier space and bitmap geometry
    localparam int MAX_IDS   = 64;
    localparam int WORD_BITS = 32;
    localparam int ID_WORDS  = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (ID_WORDS > 1) ? $clog2(ID_WORDS) : 1;
    localparam int ID_W      = 8;
    localparam int BIT_W     = 5;

    // Ids held by the last word; the bits above them never take part
    localparam int LAST_BITS = MAX_IDS - (ID_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_VALID =
        WORD_BITS'((64'(1) << LAST_BITS) - 64'(1));
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(ID_WORDS - 1);
    localparam logic [ID_W:0] ID_LIMIT = (ID_W + 1)'(MAX_IDS);

    typedef enum logic [1:0] {
        REQ_RESERVE = 2'd0,
        REQ_ALLOC   = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_QUERY   = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type         req_type;
        logic [ID_W-1:0]   asid;
    } t_req;

    typedef struct packed {
        logic              status;
        logic [ID_W-1:0]   asid_out;
        logic              active;
    } t_rsp;

    // Write port of the bitmap store
    typedef struct packed {
        logic                  en;
        logic [WORD_AW-1:0]    addr;
        logic [WORD_BITS-1:0]  data;
    } t_wr_req;

    typedef struct packed {
        logic              found;
        logic [BIT_W-1:0]  idx;
    } t_free_bit;

    // Lowest clear bit of a bitmap word
    function automatic t_free_bit first_zero(input logic [WORD_BITS-1:0] w);
        t_free_bit r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r.found = 1'b1;
                r.idx   = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/bia_if.sv
// Valid/ready channel interfaces for requests and responses.
interface bia_req_if;
    logic          valid;
    logic          ready;
    bia_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bia_rsp_if;
    logic          valid;
    logic          ready;
    bia_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/bia_word_store.sv
// Bitmap word memory with per-word valid bits; an unwritten word reads as all free.
module bia_word_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [bia_pkg::WORD_AW-1:0]       i_rd_addr,
    input  bia_pkg::t_wr_req                  i_wr,
    output logic [bia_pkg::WORD_BITS-1:0]     o_rd_data
);

    logic [bia_pkg::WORD_BITS-1:0] r_mem [bia_pkg::ID_WORDS];
    logic [bia_pkg::ID_WORDS-1:0]  r_word_valid;
    logic [bia_pkg::WORD_BITS-1:0] r_rd_data;
    logic                          r_rd_valid;

    // Write the word and take the registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Track which words hold written data; reset marks every word free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_valid <= '0;
            r_rd_valid   <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_word_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_valid <= r_word_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

### hw/rtl/bitmap_id_allocator.sv
// Top level of the bitmap identifier allocator.
//
// Requests arrive on i_req (req_type, asid) and each gives exactly one
// response on o_rsp (status, asid_out, active), in order. Both channels
// transfer on a rising edge with valid and ready high.
// One request is worked on at a time: the bitmap word is read from the
// store (a registered read), modified and written back.
// Reserve, release and query pass through READ, MOD and DONE before
// the next request is taken; an id out of range goes straight to DONE.
// Allocate reads words in turn from word 0 through READ and MOD until
// a free bit or the last word; one word's read-modify-write sets the rate.
// The response sits in an output register, so the next request is taken
// while a response still waits; a stalled receiver holds the block once
// a second response is ready.
// Reset (synchronous, active low) marks every id free at once through
// per-word valid bits; no clearing pass is needed.
module bitmap_id_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bia_req_if.sink       i_req,
    bia_rsp_if.source     o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MOD,
        S_DONE
    } t_state;

    t_state                          r_state;
    bia_pkg::t_req_type              r_kind;
    logic [bia_pkg::WORD_AW-1:0]     r_word;
    logic [bia_pkg::BIT_W-1:0]       r_bit;
    bia_pkg::t_rsp                   r_res;
    logic                            r_out_valid;
    bia_pkg::t_rsp                   r_out;

    logic [bia_pkg::WORD_BITS-1:0]   rd_word;
    logic [bia_pkg::WORD_BITS-1:0]   bit_mask;
    logic [bia_pkg::WORD_BITS-1:0]   scan_word;
    bia_pkg::t_free_bit              free_bit;
    bia_pkg::t_wr_req                wr;
    logic                            in_xfer;
    logic                            out_free;
    logic                            is_last;

    bia_word_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_word),
        .i_wr      (wr),
        .o_rd_data (rd_word)
    );

    assign in_xfer  = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign is_last  = (r_word == bia_pkg::LAST_WORD);
    assign bit_mask = bia_pkg::WORD_BITS'(1) << r_bit;

    // Treat ids past the limit in the last word as taken
    assign scan_word = is_last ? (rd_word | ~bia_pkg::LAST_VALID) : rd_word;
    assign free_bit  = bia_pkg::first_zero(scan_word);

    // Write back the modified word for reserve, release and a successful allocate; query writes nothing
    always_comb begin
        wr.en   = 1'b0;
        wr.addr = r_word;
        wr.data = rd_word;
        if (r_state == S_MOD) begin
            unique case (r_kind)
                bia_pkg::REQ_RESERVE: begin
                    wr.en   = 1'b1;
                    wr.data = rd_word | bit_mask;
                end
                bia_pkg::REQ_RELEASE: begin
                    wr.en   = 1'b1;
                    wr.data = rd_word & ~bit_mask;
                end
                bia_pkg::REQ_ALLOC: begin
                    wr.en   = free_bit.found;
                    wr.data = rd_word | (bia_pkg::WORD_BITS'(1) << free_bit.idx);
                end
                default: begin
                    wr.en = 1'b0;
                end
            endcase
        end
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // Sequence one request and hold the response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Load a finished response, or drop the one just transferred
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_kind         <= i_req.payload.req_type;
                        r_bit          <= i_req.payload.asid[bia_pkg::BIT_W-1:0];
                        r_res.asid_out <= '0;
                        r_res.active   <= 1'b0;
                        if (i_req.payload.req_type == bia_pkg::REQ_ALLOC) begin
                            r_res.status <= 1'b0;
                            r_word       <= '0;
                            r_state      <= S_READ;
                        end else if ({1'b0, i_req.payload.asid} >= bia_pkg::ID_LIMIT) begin
                            r_res.status <= 1'b1;
                            r_state      <= S_DONE;
                        end else begin
                            r_res.status <= 1'b0;
                            r_word  <= bia_pkg::WORD_AW'(i_req.payload.asid >> bia_pkg::BIT_W);
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    priority if (r_kind == bia_pkg::REQ_QUERY) begin
                        r_res.active <= rd_word[r_bit];
                        r_state      <= S_DONE;
                    end else if (r_kind != bia_pkg::REQ_ALLOC) begin
                        r_state <= S_DONE;
                    end else if (free_bit.found) begin
                        r_res.asid_out <= bia_pkg::ID_W'({r_word, free_bit.idx});
                        r_state        <= S_DONE;
                    end else if (is_last) begin
                        r_res.status <= 1'b1;
                        r_state      <= S_DONE;
                    end else begin
                        r_word  <= r_word + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/bia_checker.sv
// Port-level checks of the allocator, bound to the top level.
module bia_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rsp_valid,
    input  logic          i_rsp_ready,
    input  bia_pkg::t_rsp i_rsp_payload
);

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_payload))
        else $error("response changed while stalled");

    // A granted id other than zero is never an error and never a query answer
    a_grant_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_payload.asid_out != '0) |->
            !i_rsp_payload.status && !i_rsp_payload.active)
        else $error("grant together with error or active flag");

    // An active answer carries an ok status
    a_active_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_payload.active |-> !i_rsp_payload.status)
        else $error("active reported with error status");

    // Granted ids stay below the limit
    a_grant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |->
            ({1'b0, i_rsp_payload.asid_out} < bia_pkg::ID_LIMIT))
        else $error("granted id out of range");

    // No response straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);
